>>> rtl/core/ept_pkg.sv
package ept_pkg;

	localparam int POS_W     = 32;
	localparam int TIME_W    = 32;
	localparam int DELTA_W   = 20;
	localparam int FUNC_W    = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int FRAC_W    = 16;

	// Restoring divider: one quotient bit per cycle, t has FRAC_W bits.
	localparam int DIV_STEPS = FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Multiplier operand and product widths.
	localparam int MUL_A_W = POS_W + 1;
	localparam int MUL_B_W = FRAC_W + 2;
	localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

	localparam logic [FRAC_W:0]    Q_ONE    = 17'd65536;
	localparam logic [MUL_B_W-1:0] SMOOTH_K = 18'd196608;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	typedef enum logic [MODE_W-1:0] {
		EASE_LINEAR = 2'd0,
		EASE_SMOOTH = 2'd1,
		EASE_IN     = 2'd2,
		EASE_OUT    = 2'd3
	} ease_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X     = 3'd0,
		REG_START_Y     = 3'd1,
		REG_END_X       = 3'd2,
		REG_END_Y       = 3'd3,
		REG_DURATION    = 3'd4,
		REG_EASING_MODE = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SQ,
		ST_EASE,
		ST_SMOOTH,
		ST_LX,
		ST_LY,
		ST_FY,
		ST_EMIT_END,
		ST_EMIT_CALC
	} state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_SMOOTH,
		MUL_LX,
		MUL_LY
	} mul_sel_t;

	typedef enum logic [1:0] {
		E_T,
		E_PROD,
		E_INV
	} e_src_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [DELTA_W-1:0] delta_time;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic                    done_res;
	} out_item_t;

	typedef struct packed {
		logic     age_clr;
		logic     age_add;
		logic     div_start;
		logic     div_step;
		mul_sel_t mul_sel;
		logic     e_load;
		e_src_t   e_src;
		logic     pos_x_load;
		logic     pos_y_load;
		logic     out_load;
		logic     out_end;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  dur_zero;
		logic  age_reached;
		ease_t mode;
		logic  div_last;
		logic  slot_free;
	} dp_sts_t;

endpackage

>>> rtl/core/ept_ctrl.sv
module ept_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ept_pkg::FUNC_W-1:0]    func,
	input  ept_pkg::dp_sts_t              sts,
	output ept_pkg::ctrl_cmd_t            cmd
);
	import ept_pkg::*;

	state_t state_q, state_d;
	logic   running_q, running_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			running_q <= running_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		running_d   = running_q;
		cmd         = '0;
		cmd.mul_sel = MUL_SQ;
		cmd.e_src   = E_T;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_START: begin
							running_d   = 1'b1;
							cmd.age_clr = 1'b1;
						end
						FUNC_FINISH: begin
							if (running_q) begin
								running_d = 1'b0;
								state_d   = ST_EMIT_END;
							end
						end
						FUNC_TICK: begin
							if (running_q) begin
								if (sts.dur_zero) begin
									running_d = 1'b0;
									state_d   = ST_EMIT_END;
								end else begin
									cmd.age_add = 1'b1;
									state_d     = ST_CHECK;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (sts.age_reached) begin
					running_d = 1'b0;
					state_d   = ST_EMIT_END;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_sel = MUL_SQ;
				state_d     = ST_EASE;
			end
			ST_EASE: begin
				case (sts.mode)
					EASE_SMOOTH: begin
						cmd.mul_sel = MUL_SMOOTH;
						state_d     = ST_SMOOTH;
					end
					EASE_IN: begin
						cmd.e_load = 1'b1;
						cmd.e_src  = E_PROD;
						state_d    = ST_LX;
					end
					EASE_OUT: begin
						cmd.e_load = 1'b1;
						cmd.e_src  = E_INV;
						state_d    = ST_LX;
					end
					default: begin
						cmd.e_load = 1'b1;
						cmd.e_src  = E_T;
						state_d    = ST_LX;
					end
				endcase
			end
			ST_SMOOTH: begin
				cmd.e_load = 1'b1;
				cmd.e_src  = E_PROD;
				state_d    = ST_LX;
			end
			ST_LX: begin
				cmd.mul_sel = MUL_LX;
				state_d     = ST_LY;
			end
			ST_LY: begin
				cmd.mul_sel    = MUL_LY;
				cmd.pos_x_load = 1'b1;
				state_d        = ST_FY;
			end
			ST_FY: begin
				cmd.pos_y_load = 1'b1;
				state_d        = ST_EMIT_CALC;
			end
			ST_EMIT_END: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_end  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMIT_CALC: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/ept_dpath.sv
module ept_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]     cfg_data,
	input  logic [ept_pkg::DELTA_W-1:0]   delta_time,
	input  ept_pkg::ctrl_cmd_t            cmd,
	output ept_pkg::dp_sts_t              sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ept_pkg::out_item_t            out_item
);
	import ept_pkg::*;

	logic [POS_W-1:0]  start_x_q, start_y_q, end_x_q, end_y_q;
	logic [TIME_W-1:0] dur_q;
	ease_t             mode_q;

	logic [TIME_W-1:0] age_q;
	logic [TIME_W:0]   age_sum;

	logic [TIME_W-1:0]    rem_q;
	logic [FRAC_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W:0]      rem_sh;
	logic                 rem_ge;

	logic [FRAC_W:0]             t17, u17, sq_op, prod_hi, e_q;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]          mul_b;
	logic signed [PROD_W-1:0]    prod_d, prod_q;
	logic [POS_W-1:0]            pos_x_q, pos_y_q;

	logic      out_valid_q;
	out_item_t out_q;
	logic      slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			dur_q     <= '0;
			mode_q    <= EASE_LINEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X:     start_x_q <= cfg_data[POS_W-1:0];
				REG_START_Y:     start_y_q <= cfg_data[POS_W-1:0];
				REG_END_X:       end_x_q   <= cfg_data[POS_W-1:0];
				REG_END_Y:       end_y_q   <= cfg_data[POS_W-1:0];
				REG_DURATION:    dur_q     <= cfg_data[TIME_W-1:0];
				REG_EASING_MODE: mode_q    <= ease_t'(cfg_data[MODE_W-1:0]);
				default: ;
			endcase
		end
	end

	// The age saturates instead of wrapping.
	assign age_sum = {1'b0, age_q} + (TIME_W+1)'(delta_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (cmd.age_clr) begin
			age_q <= '0;
		end else if (cmd.age_add) begin
			age_q <= age_sum[TIME_W] ? '1 : age_sum[TIME_W-1:0];
		end
	end

	// Restoring division of age * 2^16 by duration; age is below duration here,
	// so the remainder always fits in TIME_W bits.
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, dur_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= age_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? TIME_W'(rem_sh - {1'b0, dur_q}) : rem_sh[TIME_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
		end
	end

	assign t17     = {1'b0, quo_q};
	assign u17     = Q_ONE - t17;
	assign sq_op   = (mode_q == EASE_OUT) ? u17 : t17;
	assign prod_hi = prod_q[2*FRAC_W:FRAC_W];

	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = $signed(MUL_A_W'(sq_op));
				mul_b = MUL_B_W'(sq_op);
			end
			MUL_SMOOTH: begin
				mul_a = $signed(MUL_A_W'(prod_hi));
				mul_b = SMOOTH_K - {1'b0, quo_q, 1'b0};
			end
			MUL_LX: begin
				mul_a = $signed({end_x_q[POS_W-1], end_x_q} - {start_x_q[POS_W-1], start_x_q});
				mul_b = MUL_B_W'(e_q);
			end
			MUL_LY: begin
				mul_a = $signed({end_y_q[POS_W-1], end_y_q} - {start_y_q[POS_W-1], start_y_q});
				mul_b = MUL_B_W'(e_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * $signed({1'b0, mul_b});

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.e_load) begin
			case (cmd.e_src)
				E_PROD:  e_q <= prod_hi;
				E_INV:   e_q <= Q_ONE - prod_hi;
				default: e_q <= t17;
			endcase
		end
	end

	// The arithmetic shift of the signed product floors toward minus infinity.
	always_ff @(posedge clk) begin
		if (cmd.pos_x_load) begin
			pos_x_q <= start_x_q + prod_q[FRAC_W+POS_W-1:FRAC_W];
		end
		if (cmd.pos_y_load) begin
			pos_y_q <= start_y_q + prod_q[FRAC_W+POS_W-1:FRAC_W];
		end
	end

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.pos_x    <= cmd.out_end ? end_x_q : pos_x_q;
			out_q.pos_y    <= cmd.out_end ? end_y_q : pos_y_q;
			out_q.done_res <= cmd.out_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign sts.dur_zero    = (dur_q == '0);
	assign sts.age_reached = (age_q >= dur_q);
	assign sts.mode        = mode_q;
	assign sts.div_last    = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign sts.slot_free   = slot_free;

endmodule

>>> rtl/core/eased_2d_position_tween_unit.sv
// Channel   Signals                        Moves
// -------   ----------------------------   ---------------------------------
// in        in_valid, in_stall, in_item    command item: func, delta_time
// out       out_valid, out_stall, out_item result item: pos_x, pos_y, done_res
// cfg       cfg_we, cfg_index, cfg_data    register write, no wait
//
// A start item gives no result. A finish or a snap goes through the end-emit state to the
// output register, and a tick that reaches the end first goes through the age check.
// A tick in progress checks the age, runs the bit-per-cycle divider for t, makes passes
// through one shared multiplier (an extra pass for smoothstep) and loads the output
// register.
// Reset clears the registers, the age and the running flag; the block works on one
// item at a time and takes the next while a result waits in the output register.
// A result that is still held back by out_stall keeps the next result, and so the
// input, waiting.
module eased_2d_position_tween_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ept_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ept_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]     cfg_data
);
	import ept_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	ept_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (in_item.func),
		.sts      (sts),
		.cmd      (cmd)
	);

	ept_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.delta_time (in_item.delta_time),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

`ifndef SYNTH
	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.slot_free)
		else $error("result loaded while the output item is still pending");

	// A start item never produces a result.
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_item.func == FUNC_START) && !out_valid)
		|=> !out_valid)
		else $error("start item produced a result");

	// Results are only loaded while an item is in work.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> in_stall)
		else $error("result loaded while the controller is idle");
`endif

endmodule

>>> tb/tween_checker.sv
module tween_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  ept_pkg::in_item_t             in_item,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  ept_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            expect_count
);
	import ept_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// Shadow copies of the registers and the tween state.
	logic [POS_W-1:0]  from_x, from_y, to_x, to_y;
	logic [TIME_W-1:0] span_time;
	ease_t             curve;
	logic              active;
	logic [TIME_W-1:0] age;

	out_item_t pos_expect_q[$];

	function automatic logic [FRAC_W:0] ease_value(ease_t mode, logic [FRAC_W:0] t);
		logic [63:0] tt, sq, u;
		tt = 64'(t);
		sq = (tt * tt) >> 16;
		case (mode)
			EASE_SMOOTH: return (FRAC_W+1)'((sq * (64'd196608 - 2 * tt)) >> 16);
			EASE_IN:     return (FRAC_W+1)'(sq);
			EASE_OUT: begin
				u = 64'd65536 - tt;
				return (FRAC_W+1)'(64'd65536 - ((u * u) >> 16));
			end
			default:     return (FRAC_W+1)'(tt);
		endcase
	endfunction

	// Floor of the eased step, then wrapped to the position width.
	function automatic logic [POS_W-1:0] lerp_axis(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
			logic [FRAC_W:0] e);
		logic signed [63:0] gap, prod;
		gap  = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
		prod = gap * $signed({47'd0, e});
		return a + prod[47:16];
	endfunction

	function automatic void queue_end_point();
		out_item_t res;
		res.pos_x    = to_x;
		res.pos_y    = to_y;
		res.done_res = 1'b1;
		active       = 1'b0;
		pos_expect_q.push_back(res);
	endfunction

	function automatic void tween_predict(in_item_t it);
		logic [TIME_W:0]          sum;
		logic [TIME_W+FRAC_W-1:0] num;
		logic [FRAC_W:0]          t, e;
		out_item_t                res;
		case (it.func)
			FUNC_START: begin
				active = 1'b1;
				age    = '0;
			end
			FUNC_FINISH: begin
				if (active)
					queue_end_point();
			end
			FUNC_TICK: begin
				if (active) begin
					if (span_time == '0) begin
						queue_end_point();
					end else begin
						sum = {1'b0, age} + (TIME_W+1)'(it.delta_time);
						age = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
						if (age >= span_time) begin
							queue_end_point();
						end else begin
							num          = {age, 16'd0};
							t            = (FRAC_W+1)'(num / span_time);
							e            = ease_value(curve, t);
							res.pos_x    = lerp_axis(from_x, to_x, e);
							res.pos_y    = lerp_axis(from_y, to_y, e);
							res.done_res = 1'b0;
							pos_expect_q.push_back(res);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_x       = '0;
			from_y       = '0;
			to_x         = '0;
			to_y         = '0;
			span_time    = '0;
			curve        = EASE_LINEAR;
			active       = 1'b0;
			age          = '0;
			fail_count   = 0;
			expect_count = 0;
			pos_expect_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (pos_expect_q.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("unexpected result: x=%h y=%h done=%b",
							out_item.pos_x, out_item.pos_y, out_item.done_res);
					fail_count++;
				end else if (out_item !== pos_expect_q[0]) begin
					if (fail_count < REPORT_LIMIT)
						$display("mismatch: expected x=%h y=%h done=%b, got x=%h y=%h done=%b",
							pos_expect_q[0].pos_x, pos_expect_q[0].pos_y,
							pos_expect_q[0].done_res, out_item.pos_x, out_item.pos_y,
							out_item.done_res);
					fail_count++;
					void'(pos_expect_q.pop_front());
				end else begin
					void'(pos_expect_q.pop_front());
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:     from_x    = cfg_data;
					REG_START_Y:     from_y    = cfg_data;
					REG_END_X:       to_x      = cfg_data;
					REG_END_Y:       to_y      = cfg_data;
					REG_DURATION:    span_time = cfg_data;
					REG_EASING_MODE: curve     = ease_t'(cfg_data[MODE_W-1:0]);
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tween_predict(in_item);
			expect_count = pos_expect_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
module tb_top;
	import ept_pkg::*;

	localparam logic [FUNC_W-1:0]    FUNC_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
	localparam logic [DELTA_W-1:0]   STEP_MAX      = 20'hFFFFF;
	localparam int                   SETTLE_CYCLES = 40;
	localparam int                   HOLD_CYCLES   = 300;
	localparam int                   RANDOM_ITEMS  = 440;
	localparam int                   LONG_TICKS    = 24;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   expect_count;

	logic        sender_gaps = 1'b0;
	logic        recv_stalls = 1'b0;
	logic        hold_req    = 1'b0;
	logic [31:0] cur_span;
	int          stall_left;
	int          n_sent;
	int          seq;
	int          n_ticks;

	eased_2d_position_tween_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tween_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.expect_count (expect_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAIL eased_2d_position_tween_unit");
		$finish;
	end

	function automatic int unsigned pick_gap();
		return ($urandom_range(9, 0) < 8) ? $urandom_range(3, 1) : $urandom_range(40, 10);
	endfunction

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(5, 0))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'($signed($urandom_range(2_000_000, 0)) - 1_000_000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_span();
		case ($urandom_range(11, 0))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom_range(16, 1);
			default: return $urandom_range(32'h0080_0000, 32'h0001_0000);
		endcase
	endfunction

	// Steps sized so that a tween usually takes several ticks.
	function automatic logic [DELTA_W-1:0] pick_step(logic [31:0] span);
		logic [31:0] s;
		if (span == '0 || $urandom_range(7, 0) == 0)
			return DELTA_W'($urandom());
		s = span / $urandom_range(12, 2) + $urandom_range(3, 0);
		return (s > 32'(STEP_MAX)) ? STEP_MAX : s[DELTA_W-1:0];
	endfunction

	// The receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (recv_stalls && $urandom_range(3, 0) == 0) begin
				stall_left = pick_gap() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic [FUNC_W-1:0] fn, logic [DELTA_W-1:0] dt);
		in_item_t it;
		@(negedge clk);
		if (sender_gaps && $urandom_range(2, 0) == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
		it.func       = fn;
		it.delta_time = dt;
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expect_count != 0) @(negedge clk);
	endtask

	// A start or an inactive tick gives no result, so the block may still be busy.
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	task automatic program_tween(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey, logic [31:0] span, logic [31:0] mode_word);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_DURATION, span);
		write_reg(REG_EASING_MODE, mode_word);
		// Writes past the last register must leave every register alone.
		write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_span = span;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_span  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Inactive block, registers at reset: nothing comes out until a start.
		sender_gaps = 1'b1;
		recv_stalls = 1'b1;
		send_item(FUNC_TICK, STEP_MAX);
		send_item(FUNC_FINISH, '0);
		send_item(FUNC_SPARE, STEP_MAX);
		send_item(FUNC_START, '0);
		send_item(FUNC_TICK, '0);
		settle();

		// Widest span in both directions, linear, walked right up to the end.
		program_tween(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0004_0000, 32'(EASE_LINEAR));
		send_item(FUNC_START, '0);
		send_item(FUNC_TICK, '0);
		send_item(FUNC_TICK, 20'h10000);
		send_item(FUNC_START, '0);
		send_item(FUNC_TICK, 20'h3FFFF);
		send_item(FUNC_TICK, 20'h00001);
		send_item(FUNC_FINISH, '0);
		for (int m = EASE_SMOOTH; m <= EASE_OUT; m++) begin
			settle();
			program_tween(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
				32'h0002_0000, 32'(m));
			send_item(FUNC_START, '0);
			send_item(FUNC_TICK, 20'h08000);
			send_item(FUNC_TICK, 20'h18000);
			send_item(FUNC_FINISH, '0);
		end

		n_sent = 0;
		seq    = 0;
		while (n_sent < RANDOM_ITEMS) begin
			if (seq % 6 == 0) begin
				settle();
				program_tween(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_span(),
					$urandom());
			end
			seq++;
			sender_gaps = ($urandom_range(3, 0) != 0);
			recv_stalls = ($urandom_range(3, 0) != 0);
			if (seq == 9)
				hold_req = 1'b1;
			if (seq == 17)
				wait_drained();
			if ($urandom_range(4, 0) == 0)
				send_item(FUNC_SPARE, DELTA_W'($urandom()));
			send_item(FUNC_START, '0);
			n_sent++;
			n_ticks = $urandom_range(12, 1);
			for (int k = 0; k < n_ticks; k++) begin
				if ($urandom_range(9, 0) == 0) begin
					send_item(FUNC_FINISH, DELTA_W'($urandom()));
					n_sent++;
					break;
				end
				send_item(FUNC_TICK, pick_step(cur_span));
				n_sent++;
			end
			// Broken tails: a tick or a finish after the tween may already be over.
			if ($urandom_range(3, 0) == 0)
				send_item($urandom_range(1, 0) ? FUNC_TICK : FUNC_FINISH,
					DELTA_W'($urandom()));
		end

		// Longest span with the largest steps.
		settle();
		program_tween(pick_pos(), pick_pos(), pick_pos(), pick_pos(), 32'hFFFF_FFFF,
			$urandom());
		sender_gaps = 1'b0;
		recv_stalls = 1'b0;
		send_item(FUNC_START, '0);
		repeat (LONG_TICKS) send_item(FUNC_TICK, STEP_MAX);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && expect_count == 0)
			$display("PASS eased_2d_position_tween_unit");
		else
			$display("FAIL eased_2d_position_tween_unit");
		$finish;
	end

endmodule
